FILE: hdl/qxm_pkg.sv
package qxm_pkg;

  localparam int ACT_W   = 3;
  localparam int IDX_W   = 3;
  localparam int PCT_W   = 7;
  localparam int CMD_W   = 8;
  localparam int MOTORS  = 4;
  localparam int CFG_IDX_W = 2;

  // stick range
  localparam logic signed [CMD_W-1:0] STICK_MAX = 8'sd100;
  localparam logic signed [CMD_W-1:0] STICK_MIN = -8'sd100;

  // x/100 for x < 2^17 as (x * DIV100_MUL) >> DIV100_SHIFT, exact below 91180
  localparam logic [16:0] DIV100_MUL   = 17'd83887;
  localparam int          DIV100_SHIFT = 23;

  typedef enum logic [ACT_W-1:0] {
    ACT_ARM     = 3'd0,
    ACT_DISARM  = 3'd1,
    ACT_SET_ALL = 3'd2,
    ACT_SET_ONE = 3'd3,
    ACT_SET_RC  = 3'd4,
    ACT_TICK    = 3'd5
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THROTTLE_LIMIT = 2'd0,
    CFG_MIX_AUTHORITY  = 2'd1,
    CFG_RAMP_STEP      = 2'd2
  } cfg_reg_t;

  localparam logic [PCT_W-1:0] THROTTLE_LIMIT_RST = 7'd100;
  localparam logic [PCT_W-1:0] MIX_AUTHORITY_RST  = 7'd20;
  localparam logic [PCT_W-1:0] RAMP_STEP_RST      = 7'd5;

endpackage

FILE: hdl/qxm_in_if.sv
interface qxm_in_if;
  import qxm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [IDX_W-1:0]         motor_index;
  logic signed [CMD_W-1:0]  throttle_value;
  logic signed [CMD_W-1:0]  roll_cmd;
  logic signed [CMD_W-1:0]  pitch_cmd;
  logic signed [CMD_W-1:0]  yaw_cmd;

  modport source (
    output valid, action, motor_index, throttle_value, roll_cmd, pitch_cmd, yaw_cmd,
    input  ready
  );

  modport sink (
    input  valid, action, motor_index, throttle_value, roll_cmd, pitch_cmd, yaw_cmd,
    output ready
  );
endinterface

FILE: hdl/qxm_out_if.sv
interface qxm_out_if;
  import qxm_pkg::*;

  logic             valid;
  logic             ready;
  logic             armed_flag;
  logic             arm_accepted;
  logic             force_min_pulse;
  logic [PCT_W-1:0] general_throttle;
  logic [PCT_W-1:0] power_front_left;
  logic [PCT_W-1:0] power_front_right;
  logic [PCT_W-1:0] power_rear_left;
  logic [PCT_W-1:0] power_rear_right;

  modport source (
    output valid, armed_flag, arm_accepted, force_min_pulse, general_throttle,
           power_front_left, power_front_right, power_rear_left, power_rear_right,
    input  ready
  );

  modport sink (
    input  valid, armed_flag, arm_accepted, force_min_pulse, general_throttle,
           power_front_left, power_front_right, power_rear_left, power_rear_right,
    output ready
  );
endinterface

FILE: hdl/quad_x_motor_mixer_ramp_core.sv
// Stages: input stage, then state/result stage, where the result is registered.
// Throughput: one request per cycle; cmd.ready stays high whenever the result
//   register is empty or being taken in the same cycle.
// Reset (rst, synchronous, active high): disarmed, general level, targets and
//   powers zero, both stages empty, registers back to limit 100, authority 20, step 5.
module quad_x_motor_mixer_ramp_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [qxm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qxm_pkg::PCT_W-1:0]     cfg_data,
  qxm_in_if.sink                        cmd,
  qxm_out_if.source                     res
);
  import qxm_pkg::*;

  // Per motor negation mask for {yaw, pitch, roll}; order FL FR RL RR.
  localparam logic [2:0] MIX_NEG [MOTORS] = '{3'b000, 3'b101, 3'b110, 3'b011};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PCT_W-1:0] throttle_limit;
  logic [PCT_W-1:0] mix_authority;
  logic [PCT_W-1:0] ramp_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_limit <= THROTTLE_LIMIT_RST;
      mix_authority  <= MIX_AUTHORITY_RST;
      ramp_step      <= RAMP_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THROTTLE_LIMIT: throttle_limit <= cfg_data;
        CFG_MIX_AUTHORITY:  mix_authority  <= cfg_data;
        CFG_RAMP_STEP:      ramp_step      <= cfg_data;
        default: ;  // index beyond the register list: ignored
      endcase
    end
  end

  function automatic logic signed [CMD_W-1:0] clamp_stick(logic signed [CMD_W-1:0] v);
    logic signed [CMD_W-1:0] r;
    if (v < STICK_MIN)      r = STICK_MIN;
    else if (v > STICK_MAX) r = STICK_MAX;
    else                    r = v;
    return r;
  endfunction

  function automatic logic [PCT_W-1:0] clamp_thr(logic signed [CMD_W-1:0] v,
                                                 logic [PCT_W-1:0] lim);
    logic [PCT_W-1:0] r;
    if (v[CMD_W-1])                 r = '0;
    else if (v[PCT_W-1:0] > lim)    r = lim;
    else                            r = v[PCT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake. Stage 1 holds one accepted request; it moves into the state
  // and result registers when the result register is free or being drained.
  // ---------------------------------------------------------------------------
  logic s1_valid;
  logic advance;

  assign advance   = s1_valid && (!res.valid || res.ready);
  assign cmd.ready = !s1_valid || advance;

  // ---------------------------------------------------------------------------
  // Stage 1: throttle clamp and stick mixing products. The user must change the
  // registers only while idle, so using them is safe; the block does not enforce it.
  // ---------------------------------------------------------------------------
  logic signed [CMD_W-1:0] stick_c [3];
  logic signed [9:0]       mix_sum [MOTORS];
  logic signed [17:0]      mix_prod [MOTORS];

  always_comb begin
    stick_c[0] = clamp_stick(cmd.roll_cmd);
    stick_c[1] = clamp_stick(cmd.pitch_cmd);
    stick_c[2] = clamp_stick(cmd.yaw_cmd);
    for (int m = 0; m < MOTORS; m++) begin
      mix_sum[m] = '0;
      for (int a = 0; a < 3; a++) begin
        if (MIX_NEG[m][a]) mix_sum[m] = mix_sum[m] - {{2{stick_c[a][CMD_W-1]}}, stick_c[a]};
        else               mix_sum[m] = mix_sum[m] + {{2{stick_c[a][CMD_W-1]}}, stick_c[a]};
      end
      // |sum * authority| <= 300 * 127, fits 18 bits signed
      mix_prod[m] = $signed({{8{mix_sum[m][9]}}, mix_sum[m]})
                  * $signed({11'b0, mix_authority});
    end
  end

  action_t            s1_action;
  logic [IDX_W-1:0]   s1_idx;
  logic [PCT_W-1:0]   s1_level;
  logic signed [17:0] s1_mix [MOTORS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_action <= action_t'(cmd.action);
      s1_idx    <= cmd.motor_index;
      s1_level  <= clamp_thr(cmd.throttle_value, throttle_limit);
      for (int m = 0; m < MOTORS; m++) s1_mix[m] <= mix_prod[m];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: controller state. The state registers double as the result
  // payload, since they change only when a new result is loaded.
  // ---------------------------------------------------------------------------
  logic             armed;
  logic [PCT_W-1:0] general_level;
  logic [PCT_W-1:0] target [MOTORS];
  logic [PCT_W-1:0] eff    [MOTORS];
  logic             arm_ok;
  logic             force_min;

  logic             armed_next;
  logic [PCT_W-1:0] general_next;
  logic [PCT_W-1:0] target_next [MOTORS];
  logic [PCT_W-1:0] eff_next    [MOTORS];
  logic             arm_ok_next;
  logic             force_min_next;

  // RC mix: round((base*100 + mix)/100) half away from zero, then clamp.
  logic [13:0]        base_x100;
  logic signed [17:0] num   [MOTORS];
  logic               neg   [MOTORS];
  logic [15:0]        mag   [MOTORS];
  logic [16:0]        rnd   [MOTORS];
  logic [33:0]        prod  [MOTORS];
  logic [8:0]         qmag  [MOTORS];
  logic [PCT_W-1:0]   rc_tgt [MOTORS];
  // Ramp
  logic signed [7:0]  diff  [MOTORS];
  logic signed [7:0]  step_s;
  logic [PCT_W-1:0]   ramp  [MOTORS];

  always_comb begin
    base_x100 = 14'(s1_level * 14'd100);
    step_s    = $signed({1'b0, ramp_step});
    for (int m = 0; m < MOTORS; m++) begin
      num[m]  = $signed({4'b0, base_x100}) + s1_mix[m];
      neg[m]  = num[m][17];
      mag[m]  = neg[m] ? 16'(-num[m]) : num[m][15:0];
      rnd[m]  = {1'b0, mag[m]} + 17'd50;
      prod[m] = {17'b0, rnd[m]} * {17'b0, DIV100_MUL};
      qmag[m] = prod[m][DIV100_SHIFT+8:DIV100_SHIFT];
      if (neg[m])                         rc_tgt[m] = '0;
      else if (qmag[m] > {2'b0, throttle_limit}) rc_tgt[m] = throttle_limit;
      else                                rc_tgt[m] = qmag[m][PCT_W-1:0];

      diff[m] = $signed({1'b0, target[m]}) - $signed({1'b0, eff[m]});
      if (diff[m] > step_s)       ramp[m] = eff[m] + ramp_step;
      else if (diff[m] < -step_s) ramp[m] = eff[m] - ramp_step;
      else                        ramp[m] = target[m];
    end
  end

  always_comb begin
    armed_next     = armed;
    general_next   = general_level;
    arm_ok_next    = 1'b0;
    force_min_next = 1'b0;
    for (int m = 0; m < MOTORS; m++) begin
      target_next[m] = target[m];
      eff_next[m]    = eff[m];
    end
    unique case (s1_action)
      ACT_ARM: begin
        // refused while a general throttle is still requested
        if (general_level == '0) begin
          armed_next   = 1'b1;
          arm_ok_next  = 1'b1;
          general_next = '0;
          for (int m = 0; m < MOTORS; m++) begin
            target_next[m] = '0;
            eff_next[m]    = '0;
          end
        end
      end
      ACT_DISARM: begin
        armed_next     = 1'b0;
        force_min_next = 1'b1;
        general_next   = '0;
        for (int m = 0; m < MOTORS; m++) begin
          target_next[m] = '0;
          eff_next[m]    = '0;
        end
      end
      ACT_SET_ALL: begin
        general_next = s1_level;
        for (int m = 0; m < MOTORS; m++) target_next[m] = armed ? s1_level : '0;
      end
      ACT_SET_ONE: begin
        if (!s1_idx[IDX_W-1]) target_next[s1_idx[1:0]] = armed ? s1_level : '0;
      end
      ACT_SET_RC: begin
        general_next = s1_level;
        for (int m = 0; m < MOTORS; m++) target_next[m] = armed ? rc_tgt[m] : '0;
      end
      ACT_TICK: begin
        if (!armed) force_min_next = 1'b1;
        else for (int m = 0; m < MOTORS; m++) eff_next[m] = ramp[m];
      end
      default: ;  // unused action codes: state reported unchanged
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid     <= 1'b0;
      armed         <= 1'b0;
      general_level <= '0;
      arm_ok        <= 1'b0;
      force_min     <= 1'b0;
      for (int m = 0; m < MOTORS; m++) begin
        target[m] <= '0;
        eff[m]    <= '0;
      end
    end else if (advance) begin
      res.valid     <= 1'b1;
      armed         <= armed_next;
      general_level <= general_next;
      arm_ok        <= arm_ok_next;
      force_min     <= force_min_next;
      for (int m = 0; m < MOTORS; m++) begin
        target[m] <= target_next[m];
        eff[m]    <= eff_next[m];
      end
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  assign res.armed_flag        = armed;
  assign res.arm_accepted      = arm_ok;
  assign res.force_min_pulse   = force_min;
  assign res.general_throttle  = general_level;
  assign res.power_front_left  = eff[0];
  assign res.power_front_right = eff[1];
  assign res.power_rear_left   = eff[2];
  assign res.power_rear_right  = eff[3];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_reset_empty: assert property (@(posedge clk) rst |=> !res.valid && !armed && !s1_valid)
    else $error("pipeline or arm state not cleared by reset");

  a_force_min_disarmed: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.force_min_pulse |-> !res.armed_flag)
    else $error("minimum pulse forced while armed");

  a_arm_clean: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.arm_accepted |->
      res.armed_flag && res.general_throttle == '0 && res.power_front_left == '0 &&
      res.power_front_right == '0 && res.power_rear_left == '0 &&
      res.power_rear_right == '0)
    else $error("accepted arm left throttle or power set");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_action) && $stable(s1_level))
    else $error("held request in stage 1 lost or changed");

endmodule

FILE: bench/quad_x_motor_mixer_ramp_core_tb.sv
`timescale 1ns / 100ps

module quad_x_motor_mixer_ramp_core_tb;
  import qxm_pkg::*;

  // Action codes that the block leaves unused; it must report state and change nothing
  localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int BLOCK_REQS    = 146;    // requests per register setting in the random part
  localparam int BLOCKS        = 4;      // register settings per idling phase

  // One result as the block reports it; power[0..3] = FL, FR, RL, RR
  typedef struct packed {
    logic                         armed;
    logic                         accepted;
    logic                         force_min;
    logic [PCT_W-1:0]             general;
    logic [MOTORS-1:0][PCT_W-1:0] power;
  } mix_result_t;

  // One line of the directed table: either a register write or a request,
  // the latter optionally with a result typed in by hand
  typedef struct packed {
    logic             is_cfg;
    cfg_reg_t         reg_sel;
    logic [PCT_W-1:0] reg_val;
    logic [ACT_W-1:0] act;
    logic [IDX_W-1:0] idx;
    logic [CMD_W-1:0] thr;
    logic [CMD_W-1:0] roll;
    logic [CMD_W-1:0] pitch;
    logic [CMD_W-1:0] yaw;
    logic             has_fixed;
    mix_result_t      fixed;
  } plan_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PCT_W-1:0] cfg_data;

  qxm_in_if  cmd_if ();
  qxm_out_if res_if ();

  quad_x_motor_mixer_ramp_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_if),
    .res       (res_if)
  );

  // Mirror of the block: registers and state, kept at the acceptance edge
  int mdl_limit;
  int mdl_authority;
  int mdl_step;
  bit mdl_armed;
  int mdl_general;
  int mdl_target [MOTORS];
  int mdl_power  [MOTORS];

  mix_result_t expected_powers_q [$];
  plan_row_t   plan_q [$];

  int mismatch_count;
  int send_idle_pct;
  int recv_stall_pct;
  int cycle_count;

  // Typed-in result travelling with the request on the bus, read by the monitor
  logic        fixed_pending;
  mix_result_t fixed_pending_res;

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor helpers
  // ---------------------------------------------------------------------------

  // Clamp a percentage into [0, throttle limit] as the register stands
  function automatic int clamp_to_limit(int v);
    if (v < 0) v = 0;
    if (v > mdl_limit) v = mdl_limit;
    return v;
  endfunction

  function automatic int clamp_stick(logic [CMD_W-1:0] raw);
    int v;
    v = int'($signed(raw));
    if (v < int'(STICK_MIN)) v = int'(STICK_MIN);
    if (v > int'(STICK_MAX)) v = int'(STICK_MAX);
    return v;
  endfunction

  // num / 100 rounded half away from zero (SV division truncates toward zero)
  function automatic int div100_away(int num);
    if (num >= 0) return (num + 50) / 100;
    return -((-num + 50) / 100);
  endfunction

  // Works out the result of one request and moves the mirrored state on
  task automatic predict_motor_powers(input logic [ACT_W-1:0] act,
                                      input logic [IDX_W-1:0] idx,
                                      input logic [CMD_W-1:0] thr_raw,
                                      input logic [CMD_W-1:0] roll_raw,
                                      input logic [CMD_W-1:0] pitch_raw,
                                      input logic [CMD_W-1:0] yaw_raw,
                                      output mix_result_t r);
    int thr, rl, pt, yw, base, d;
    int mix [MOTORS];
    logic accepted, force_min;
    thr = int'($signed(thr_raw));
    rl  = clamp_stick(roll_raw);
    pt  = clamp_stick(pitch_raw);
    yw  = clamp_stick(yaw_raw);
    // X layout: FL + + +, FR - + -, RL + - -, RR - - +  (roll, pitch, yaw)
    mix[0] =  rl + pt + yw;
    mix[1] = -rl + pt - yw;
    mix[2] =  rl - pt - yw;
    mix[3] = -rl - pt + yw;
    accepted  = 1'b0;
    force_min = 1'b0;
    case (act)
      ACT_ARM: begin
        // refused while a general throttle is still standing
        if (mdl_general == 0) begin
          mdl_general = 0;
          for (int m = 0; m < MOTORS; m++) begin
            mdl_target[m] = 0;
            mdl_power[m]  = 0;
          end
          mdl_armed = 1'b1;
          accepted  = 1'b1;
        end
      end
      ACT_DISARM: begin
        mdl_armed   = 1'b0;
        mdl_general = 0;
        for (int m = 0; m < MOTORS; m++) begin
          mdl_target[m] = 0;
          mdl_power[m]  = 0;
        end
        force_min = 1'b1;
      end
      ACT_SET_ALL: begin
        mdl_general = clamp_to_limit(thr);
        for (int m = 0; m < MOTORS; m++) mdl_target[m] = mdl_armed ? mdl_general : 0;
      end
      ACT_SET_ONE: begin
        if (idx < MOTORS) mdl_target[idx] = mdl_armed ? clamp_to_limit(thr) : 0;
      end
      ACT_SET_RC: begin
        base = clamp_to_limit(thr);
        mdl_general = base;
        for (int m = 0; m < MOTORS; m++) begin
          if (mdl_armed)
            mdl_target[m] = clamp_to_limit(div100_away(base * 100 + mix[m] * mdl_authority));
          else
            mdl_target[m] = 0;
        end
      end
      ACT_TICK: begin
        if (!mdl_armed) begin
          force_min = 1'b1;
        end else begin
          for (int m = 0; m < MOTORS; m++) begin
            d = mdl_target[m] - mdl_power[m];
            if (d > mdl_step)       mdl_power[m] += mdl_step;
            else if (d < -mdl_step) mdl_power[m] -= mdl_step;
            else                    mdl_power[m]  = mdl_target[m];
          end
        end
      end
      default: begin
      end
    endcase
    r.armed     = mdl_armed;
    r.accepted  = accepted;
    r.force_min = force_min;
    r.general   = mdl_general[PCT_W-1:0];
    for (int m = 0; m < MOTORS; m++) r.power[m] = mdl_power[m][PCT_W-1:0];
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input int want, input int seen);
    if (want != seen) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
    end
  endtask

  task automatic check_result(input mix_result_t want, input mix_result_t seen);
    check_field("armed_flag", want.armed, seen.armed);
    check_field("arm_accepted", want.accepted, seen.accepted);
    check_field("force_min_pulse", want.force_min, seen.force_min);
    check_field("general_throttle", want.general, seen.general);
    check_field("power_front_left", want.power[0], seen.power[0]);
    check_field("power_front_right", want.power[1], seen.power[1]);
    check_field("power_rear_left", want.power[2], seen.power[2]);
    check_field("power_rear_right", want.power[3], seen.power[3]);
  endtask

  // Monitor: results are checked before the new request is predicted, so a
  // result can never be matched against the request accepted on the same edge.
  always @(posedge clk) begin : monitor
    mix_result_t pred;
    mix_result_t seen;
    if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        seen.armed     = res_if.armed_flag;
        seen.accepted  = res_if.arm_accepted;
        seen.force_min = res_if.force_min_pulse;
        seen.general   = res_if.general_throttle;
        seen.power[0]  = res_if.power_front_left;
        seen.power[1]  = res_if.power_front_right;
        seen.power[2]  = res_if.power_rear_left;
        seen.power[3]  = res_if.power_rear_right;
        if (expected_powers_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual %p", $time, seen);
        end else begin
          check_result(expected_powers_q.pop_front(), seen);
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        predict_motor_powers(cmd_if.action, cmd_if.motor_index, cmd_if.throttle_value,
                             cmd_if.roll_cmd, cmd_if.pitch_cmd, cmd_if.yaw_cmd, pred);
        // a typed-in row overrides the predictor, but state still moves on
        expected_powers_q.push_back(fixed_pending ? fixed_pending_res : pred);
      end
    end
  end

  // Result side back-pressure, redrawn every cycle
  always @(negedge clk) begin
    res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offers one request, idling at random first; returns once it is taken
  task automatic send_req(input plan_row_t row);
    bit placed;
    placed = 0;
    while (!placed) begin
      @(negedge clk);
      if ($urandom_range(0, 99) < send_idle_pct) begin
        cmd_if.valid <= 1'b0;
      end else begin
        cmd_if.valid          <= 1'b1;
        cmd_if.action         <= row.act;
        cmd_if.motor_index    <= row.idx;
        cmd_if.throttle_value <= row.thr;
        cmd_if.roll_cmd       <= row.roll;
        cmd_if.pitch_cmd      <= row.pitch;
        cmd_if.yaw_cmd        <= row.yaw;
        fixed_pending         = row.has_fixed;
        fixed_pending_res     = row.fixed;
        placed = 1;
      end
    end
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  task automatic release_cmd();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (expected_powers_q.size() != 0) @(posedge clk);
  endtask

  // Register write; the mirror follows at the write edge
  task automatic write_reg(input cfg_reg_t sel, input logic [PCT_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    case (sel)
      CFG_THROTTLE_LIMIT: mdl_limit     = val;
      CFG_MIX_AUTHORITY:  mdl_authority = val;
      CFG_RAMP_STEP:      mdl_step      = val;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------

  function automatic mix_result_t fixed_res(logic armed, logic acc, logic frc, int gen,
                                            int fl, int fr, int rl, int rr);
    mix_result_t r;
    r.armed     = armed;
    r.accepted  = acc;
    r.force_min = frc;
    r.general   = gen[PCT_W-1:0];
    r.power[0]  = fl[PCT_W-1:0];
    r.power[1]  = fr[PCT_W-1:0];
    r.power[2]  = rl[PCT_W-1:0];
    r.power[3]  = rr[PCT_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t req_row(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                                        int thr, int roll, int pitch, int yaw);
    plan_row_t row;
    row           = '0;
    row.act       = act;
    row.idx       = idx;
    row.thr       = thr[CMD_W-1:0];
    row.roll      = roll[CMD_W-1:0];
    row.pitch     = pitch[CMD_W-1:0];
    row.yaw       = yaw[CMD_W-1:0];
    return row;
  endfunction

  task automatic add_req(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                         int thr, int roll, int pitch, int yaw);
    plan_q.push_back(req_row(act, idx, thr, roll, pitch, yaw));
  endtask

  task automatic add_checked(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                             int thr, int roll, int pitch, int yaw, mix_result_t want);
    plan_row_t row;
    row           = req_row(act, idx, thr, roll, pitch, yaw);
    row.has_fixed = 1'b1;
    row.fixed     = want;
    plan_q.push_back(row);
  endtask

  task automatic add_reg(cfg_reg_t sel, logic [PCT_W-1:0] val);
    plan_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    plan_q.push_back(row);
  endtask

  task automatic build_plan();
    // reset registers: limit 100, authority 20, step 5
    add_checked(ACT_TICK,    0,   0,    0,    0,  0, fixed_res(0, 0, 1,  0, 0, 0, 0, 0));
    // disarmed set all still records the general level
    add_checked(ACT_SET_ALL, 0,  50,    0,    0,  0, fixed_res(0, 0, 0, 50, 0, 0, 0, 0));
    // arm refused with a standing general level
    add_checked(ACT_ARM,     0,   0,    0,    0,  0, fixed_res(0, 0, 0, 50, 0, 0, 0, 0));
    // disarmed rc: general clamps to zero, roll and pitch at their extremes
    add_checked(ACT_SET_RC,  7, -128, 127, -128, -1, fixed_res(0, 0, 0,  0, 0, 0, 0, 0));
    add_checked(ACT_ARM,     0,   0,    0,    0,  0, fixed_res(1, 1, 0,  0, 0, 0, 0, 0));
    // arm while armed behaves as any accepted arm
    add_checked(ACT_ARM,     0,   0,    0,    0,  0, fixed_res(1, 1, 0,  0, 0, 0, 0, 0));
    add_checked(ACT_SET_ALL, 0, 127,    0,    0,  0, fixed_res(1, 0, 0, 100, 0, 0, 0, 0));
    add_req(ACT_TICK,    0,   0,    0,    0,    0);
    add_req(ACT_SET_ONE, 0,  30,    0,    0,    0);
    // motor index beyond the four motors is ignored
    add_req(ACT_SET_ONE, 5,  90,    0,    0,    0);
    add_req(ACT_SET_ONE, 7,  -1,    0,    0,    0);
    // sticks beyond +/-100 are clamped
    add_req(ACT_SET_RC,  0,  50,  127, -128,    0);
    add_req(ACT_TICK,    0,   0,    0,    0,    0);
    add_req(ACT_SET_RC,  0,   0, -100, -100, -100);
    add_req(ACT_SET_RC,  0,  99,  100,  100,  100);
    add_req(ACT_TICK,    0,   0,    0,    0,    0);
    add_req(ACT_SPARE6,  3,  77,   12,  -12,   55);
    add_req(ACT_SPARE7,  6, -77,  -12,   12,  -55);
    add_checked(ACT_DISARM,  0,   0,    0,    0,  0, fixed_res(0, 0, 1,  0, 0, 0, 0, 0));
    add_req(ACT_SET_ONE, 1,  50,    0,    0,    0);
    // limit above one hundred, step zero, authority giving exact halves
    add_reg(CFG_THROTTLE_LIMIT, 7'd127);
    add_reg(CFG_MIX_AUTHORITY,  7'd25);
    add_reg(CFG_RAMP_STEP,      7'd0);
    add_checked(ACT_ARM,     0,   0,    0,    0,  0, fixed_res(1, 1, 0,  0, 0, 0, 0, 0));
    add_checked(ACT_SET_ALL, 0, 127,    0,    0,  0, fixed_res(1, 0, 0, 127, 0, 0, 0, 0));
    add_req(ACT_TICK,    0,   0,    0,    0,    0);
    add_req(ACT_SET_RC,  0,  10,    2,    0,    0);
    add_req(ACT_SET_RC,  0,   0,   -2,    0,    0);
    add_req(ACT_TICK,    0,   0,    0,    0,    0);
    // other extremes: limit zero, full authority, full step
    add_reg(CFG_THROTTLE_LIMIT, 7'd0);
    add_reg(CFG_MIX_AUTHORITY,  7'd100);
    add_reg(CFG_RAMP_STEP,      7'd100);
    add_req(ACT_TICK,    0,   0,    0,    0,    0);
    add_req(ACT_SET_ALL, 0, 127,    0,    0,    0);
    add_req(ACT_TICK,    0,   0,    0,    0,    0);
  endtask

  // ---------------------------------------------------------------------------
  // Random part
  // ---------------------------------------------------------------------------

  // Flight-loop like traffic: mostly ticks and mixer updates while armed,
  // with arming, disarming, out-of-range values and spare codes mixed in
  task automatic make_random_req(output plan_row_t row);
    int w;
    row = '0;
    w = $urandom_range(0, 99);
    if (w < 5)        row.act = ACT_ARM;
    else if (w < 8)   row.act = ACT_DISARM;
    else if (w < 18)  row.act = ACT_SET_ALL;
    else if (w < 30)  row.act = ACT_SET_ONE;
    else if (w < 55)  row.act = ACT_SET_RC;
    else if (w < 97)  row.act = ACT_TICK;
    else              row.act = $urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7;

    row.idx = ($urandom_range(0, 99) < 80) ? IDX_W'($urandom_range(0, 3))
                                           : IDX_W'($urandom_range(0, 7));

    w = $urandom_range(0, 99);
    if (w < 10)       row.thr = CMD_W'($urandom_range(0, 255));
    else if (w < 20)  row.thr = '0;
    else              row.thr = CMD_W'($urandom_range(0, 100));

    if ($urandom_range(0, 99) < 85) begin
      row.roll  = CMD_W'($urandom_range(0, 200) - 100);
      row.pitch = CMD_W'($urandom_range(0, 200) - 100);
      row.yaw   = CMD_W'($urandom_range(0, 200) - 100);
    end else begin
      row.roll  = CMD_W'($urandom_range(0, 255));
      row.pitch = CMD_W'($urandom_range(0, 255));
      row.yaw   = CMD_W'($urandom_range(0, 255));
    end
  endtask

  // Draws a register setting, with the extremes well represented
  task automatic write_random_regs();
    logic [PCT_W-1:0] lim, auth, step;
    case ($urandom_range(0, 5))
      0:       lim = 7'd0;
      1:       lim = 7'd100;
      2:       lim = 7'd127;
      3:       lim = PCT_W'($urandom_range(0, 127));
      default: lim = PCT_W'($urandom_range(30, 100));
    endcase
    case ($urandom_range(0, 4))
      0:       auth = 7'd0;
      1:       auth = 7'd100;
      2:       auth = PCT_W'($urandom_range(0, 127));
      default: auth = PCT_W'($urandom_range(0, 100));
    endcase
    case ($urandom_range(0, 5))
      0:       step = 7'd1;
      1:       step = 7'd100;
      2:       step = 7'd0;
      3:       step = PCT_W'($urandom_range(0, 127));
      default: step = PCT_W'($urandom_range(1, 20));
    endcase
    write_reg(CFG_THROTTLE_LIMIT, lim);
    write_reg(CFG_MIX_AUTHORITY, auth);
    write_reg(CFG_RAMP_STEP, step);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    plan_row_t row;
    int taken;
    // every block input known from time zero
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = CFG_THROTTLE_LIMIT;
    cfg_data              = '0;
    cmd_if.valid          = 1'b0;
    cmd_if.action         = ACT_ARM;
    cmd_if.motor_index    = '0;
    cmd_if.throttle_value = '0;
    cmd_if.roll_cmd       = '0;
    cmd_if.pitch_cmd      = '0;
    cmd_if.yaw_cmd        = '0;
    res_if.ready          = 1'b0;
    fixed_pending         = 1'b0;
    fixed_pending_res     = '0;
    mismatch_count        = 0;
    send_idle_pct         = 20;
    recv_stall_pct        = 47;

    // mirror starts from the reset state
    mdl_limit     = THROTTLE_LIMIT_RST;
    mdl_authority = MIX_AUTHORITY_RST;
    mdl_step      = RAMP_STEP_RST;
    mdl_armed     = 1'b0;
    mdl_general   = 0;
    for (int m = 0; m < MOTORS; m++) begin
      mdl_target[m] = 0;
      mdl_power[m]  = 0;
    end

    build_plan();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table. Register writes only go in once every result is back.
    foreach (plan_q[i]) begin
      if (plan_q[i].is_cfg) begin
        release_cmd();
        wait_drain();
        write_reg(plan_q[i].reg_sel, plan_q[i].reg_val);
      end else begin
        send_req(plan_q[i]);
      end
    end

    // Random part over three idling phases: sender 20 / receiver 47,
    // then 47 / 20, then flat out on both sides
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 20;
          recv_stall_pct = 47;
        end
        1: begin
          send_idle_pct  = 47;
          recv_stall_pct = 20;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int blk = 0; blk < BLOCKS; blk++) begin
        release_cmd();
        wait_drain();
        write_random_regs();
        taken = 0;
        while (taken < BLOCK_REQS) begin
          make_random_req(row);
          row.has_fixed = 1'b0;
          send_req(row);
          taken++;
        end
      end
    end

    release_cmd();
    wait_drain();
    // idle on so that anything stray can still show up
    repeat (6) @(posedge clk);

    if (mismatch_count == 0 && expected_powers_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog on total run length
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/qxm_pkg.sv
hdl/qxm_in_if.sv
hdl/qxm_out_if.sv
hdl/quad_x_motor_mixer_ramp_core.sv
bench/quad_x_motor_mixer_ramp_core_tb.sv
